// ===== src/joystick_direction_repeat_assert.svh =====
// Assertion macros for the joystick direction block.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef JOYSTICK_DIRECTION_REPEAT_ASSERT_SVH
`define JOYSTICK_DIRECTION_REPEAT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JDR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jdr_pkg.sv =====
// Shared types and constants for the joystick direction block.
// No dependencies.
package jdr_pkg;

    localparam int ADC_BITS     = 12;
    localparam int GAP_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_X      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_X     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_Y      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_Y     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_GAP = 3'd6;

    // Reset values
    localparam logic [ADC_BITS-1:0] ADC_CENTER_RST = 12'd2048;
    localparam logic [ADC_BITS-1:0] ADC_LOW_RST    = 12'd0;
    localparam logic [ADC_BITS-1:0] ADC_HIGH_RST   = 12'd4095;
    localparam logic [GAP_BITS-1:0] GAP_RST        = 16'd10;

    typedef struct packed {
        logic [ADC_BITS-1:0] sample_x;
        logic [ADC_BITS-1:0] sample_y;
    } jdr_in_t;

    typedef struct packed {
        logic move_up;
        logic move_down;
        logic move_left;
        logic move_right;
    } jdr_out_t;

    // Deflection flags of one axis
    typedef struct packed {
        logic below;
        logic above;
    } jdr_axis_flags_t;

    // Calibration load into the running extent of one axis
    typedef struct packed {
        logic                ld_min;
        logic                ld_max;
        logic [ADC_BITS-1:0] value;
    } jdr_ext_load_t;

endpackage

// ===== src/joystick_direction_repeat.sv =====
// Joystick direction detector with auto-repeat; top level.
// Pipeline: an accepted sample pair goes to the input register, then to the result register;
//   throughput is one sample pair per cycle unless the result side stalls (m_ready low).
// Reset (aresetn low, synchronous): calibration registers, running extents and
//   hold-off counters return to their defaults; both pipeline registers empty.
// Depends on jdr_pkg, jdr_axis, jdr_repeat and joystick_direction_repeat_assert.svh.
`include "joystick_direction_repeat_assert.svh"

module joystick_direction_repeat #(
    parameter int HOLD_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // sample pair channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  jdr_pkg::jdr_in_t                  s_payload,
    // direction event channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output jdr_pkg::jdr_out_t                 m_payload,
    // calibration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [jdr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [jdr_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import jdr_pkg::*;

    // Calibration registers
    logic [ADC_BITS-1:0] center_x_reg, center_y_reg;
    logic [GAP_BITS-1:0] repeat_gap_reg;

    // Pipeline registers
    logic     in_valid_reg, in_valid_next;
    jdr_in_t  in_payload_reg;
    logic     out_valid_reg, out_valid_next;
    jdr_out_t out_payload_reg;

    logic                cfg_fire;
    logic [ADC_BITS-1:0] cfg_adc_val;
    logic                advance;
    logic                step;
    jdr_ext_load_t       load_x, load_y;
    jdr_axis_flags_t     flags_x, flags_y;
    jdr_out_t            fires;

    // ------------------------------------------------------------------
    // Calibration port: always ready. Writes must arrive only while idle; the block does not enforce this.
    // A write to a low/high register reloads that axis's running extent,
    // which is the only place the calibrated minimum and maximum live.
    // ------------------------------------------------------------------
    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign cfg_adc_val = cfg_wdata[ADC_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= ADC_CENTER_RST;
            center_y_reg   <= ADC_CENTER_RST;
            repeat_gap_reg <= GAP_RST;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_CENTER_X:   center_x_reg   <= cfg_adc_val;
                REG_CENTER_Y:   center_y_reg   <= cfg_adc_val;
                REG_REPEAT_GAP: repeat_gap_reg <= cfg_wdata[GAP_BITS-1:0];
                REG_LOW_X, REG_HIGH_X, REG_LOW_Y, REG_HIGH_Y: begin
                    // loaded into the running extents of the axis units
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_comb begin
        load_x.ld_min = cfg_fire && (cfg_index == REG_LOW_X);
        load_x.ld_max = cfg_fire && (cfg_index == REG_HIGH_X);
        load_x.value  = cfg_adc_val;
        load_y.ld_min = cfg_fire && (cfg_index == REG_LOW_Y);
        load_y.ld_max = cfg_fire && (cfg_index == REG_HIGH_Y);
        load_y.value  = cfg_adc_val;
    end

    // ------------------------------------------------------------------
    // Handshake: the result register frees itself when taken, so the input
    // register can advance whenever the result slot is empty or draining.
    // State (extents, hold-off counters) updates on the same edge that loads
    // the result, so the next sample pair sees the updated state.
    // ------------------------------------------------------------------
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the sample pair until it moves into the result stage
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_payload_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_payload_reg <= fires;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_payload_reg;

    // ------------------------------------------------------------------
    // Per-axis deflection test. X below centre is right, Y at or above is up.
    // ------------------------------------------------------------------
    jdr_axis u_axis_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .center  (center_x_reg),
        .sample  (in_payload_reg.sample_x),
        .load    (load_x),
        .flags   (flags_x)
    );

    jdr_axis u_axis_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .center  (center_y_reg),
        .sample  (in_payload_reg.sample_y),
        .load    (load_y),
        .flags   (flags_y)
    );

    // ------------------------------------------------------------------
    // Hold-off counters, one per direction.
    // ------------------------------------------------------------------
    jdr_repeat #(.HOLD_BITS(HOLD_BITS)) u_rep_up (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .active  (flags_y.above),
        .gap     (repeat_gap_reg),
        .fire    (fires.move_up)
    );

    jdr_repeat #(.HOLD_BITS(HOLD_BITS)) u_rep_down (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .active  (flags_y.below),
        .gap     (repeat_gap_reg),
        .fire    (fires.move_down)
    );

    jdr_repeat #(.HOLD_BITS(HOLD_BITS)) u_rep_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .active  (flags_x.above),
        .gap     (repeat_gap_reg),
        .fire    (fires.move_left)
    );

    jdr_repeat #(.HOLD_BITS(HOLD_BITS)) u_rep_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .active  (flags_x.below),
        .gap     (repeat_gap_reg),
        .fire    (fires.move_right)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `JDR_ASSERT_SAME(a_up_down_excl, out_valid_reg,
        !(out_payload_reg.move_up && out_payload_reg.move_down),
        "up and down fired together")
    `JDR_ASSERT_SAME(a_left_right_excl, out_valid_reg,
        !(out_payload_reg.move_left && out_payload_reg.move_right),
        "left and right fired together")
    `JDR_ASSERT_NEXT(a_in_held, in_valid_reg && !advance,
        in_valid_reg && $stable(in_payload_reg),
        "stalled sample pair lost or changed")
    `JDR_ASSERT_NEXT(a_step_gives_result, step, out_valid_reg,
        "processed sample pair gave no result")

endmodule

// ===== src/jdr_axis.sv =====
// One joystick axis: running extent registers and the 0.8-span deflection test.
// Depends on jdr_pkg.
module jdr_axis (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [jdr_pkg::ADC_BITS-1:0]  center,
    input  logic [jdr_pkg::ADC_BITS-1:0]  sample,
    input  jdr_pkg::jdr_ext_load_t        load,
    output jdr_pkg::jdr_axis_flags_t      flags
);
    import jdr_pkg::*;

    localparam int PW = ADC_BITS + 3;

    logic [ADC_BITS-1:0] run_min_reg, run_min_next;
    logic [ADC_BITS-1:0] run_max_reg, run_max_next;
    logic                is_below;
    logic [ADC_BITS-1:0] mn_eff, mx_eff;
    logic [ADC_BITS-1:0] dev, span;
    logic [PW-1:0]       dev5, span4;

    always_comb begin
        is_below = sample < center;
        // widen the extent to the sample first so the span never goes negative
        mn_eff   = (sample < run_min_reg) ? sample : run_min_reg;
        mx_eff   = (sample > run_max_reg) ? sample : run_max_reg;
        if (is_below) begin
            dev  = center - sample;
            span = center - mn_eff;
        end else begin
            dev  = sample - center;
            span = mx_eff - center;
        end
        dev5  = (PW'(dev) << 2) + PW'(dev);
        span4 = PW'(span) << 2;
        flags.below = is_below && (dev5 > span4);
        flags.above = !is_below && (dev5 > span4);

        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        if (load.ld_min) begin
            run_min_next = load.value;
        end else if (step && is_below) begin
            run_min_next = mn_eff;
        end
        if (load.ld_max) begin
            run_max_next = load.value;
        end else if (step && !is_below) begin
            run_max_next = mx_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_min_reg <= ADC_LOW_RST;
            run_max_reg <= ADC_HIGH_RST;
        end else begin
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
        end
    end

endmodule

// ===== src/jdr_repeat.sv =====
// Hold-off counter for one direction: fire on entry, then once per gap+1 samples.
// Depends on jdr_pkg.
module jdr_repeat #(
    parameter int HOLD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          active,
    input  logic [jdr_pkg::GAP_BITS-1:0]  gap,
    output logic                          fire
);
    import jdr_pkg::*;

    logic [HOLD_BITS-1:0] hold_reg, hold_next;

    always_comb begin
        fire      = active && (hold_reg == '0);
        hold_next = hold_reg;
        if (step) begin
            if (!active) begin
                hold_next = '0;
            end else if (hold_reg == '0) begin
                hold_next = HOLD_BITS'(gap);
            end else begin
                hold_next = hold_reg - HOLD_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else begin
            hold_reg <= hold_next;
        end
    end

endmodule

// ===== tb/joystick_direction_repeat_tb.sv =====
// Self-checking testbench for joystick_direction_repeat: directed table, then gesture-shaped
// random sample pairs under eight calibration settings and four idling patterns.
// Depends on jdr_pkg and the joystick_direction_repeat RTL.
module joystick_direction_repeat_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jdr_pkg::*;

    localparam int ADC_MAX         = (1 << ADC_BITS) - 1;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 150;
    // Index beyond the register file; a write there must be dropped.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

    // Gesture zones for one axis
    localparam int ZONE_REST   = 0;
    localparam int ZONE_LOW    = 1;
    localparam int ZONE_HIGH   = 2;
    localparam int ZONE_LOW_TH = 3;
    localparam int ZONE_HIGH_TH = 4;
    localparam int ZONE_ANY    = 5;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    jdr_in_t                  s_payload;
    logic                     m_valid;
    logic                     m_ready;
    jdr_out_t                 m_payload;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    joystick_direction_repeat dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: calibration as the block should hold it, the
    // running extents of both axes and the four hold-off counters.
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0] cen_x, cen_y;
    logic [ADC_BITS-1:0] ext_min_x, ext_max_x, ext_min_y, ext_max_y;
    logic [GAP_BITS-1:0] rep_gap;
    logic [GAP_BITS-1:0] hold_up, hold_down, hold_left, hold_right;

    jdr_out_t pending_moves[$];   // expected direction results, oldest first
    int       fail_count    = 0;
    int       samples_sent  = 0;
    int       moves_checked = 0;
    int       events_fired  = 0;
    int       settings_used = 1;
    int       src_idle_pct  = 0;
    int       sink_stall_pct = 0;

    // Directed stimulus: pair, repeat count, and a typed expectation where
    // the result can be read straight off the reset calibration.
    typedef struct packed {
        logic [ADC_BITS-1:0] x;
        logic [ADC_BITS-1:0] y;
        logic [7:0]          reps;
        logic                typed;
        jdr_out_t            want;
    } stim_row_t;

    localparam int DIR_ROWS = 14;
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        // exactly on centre: no deviation, nothing fires
        {12'd2048, 12'd2048, 8'd1,  1'b1, 4'b0000},
        // full deflection right and up: both fire on entry
        {12'd0,    12'd4095, 8'd1,  1'b1, 4'b1001},
        // still held: hold-off suppresses the repeat
        {12'd0,    12'd4095, 8'd1,  1'b1, 4'b0000},
        // swap to left and down: fresh entry on both, old ones cleared
        {12'd4095, 12'd0,    8'd1,  1'b1, 4'b0110},
        {12'd2048, 12'd2048, 8'd1,  1'b1, 4'b0000},
        // just past the 0.8 threshold on both axes
        {12'd409,  12'd3686, 8'd1,  1'b0, 4'b0000},
        {12'd2048, 12'd2048, 8'd1,  1'b0, 4'b0000},
        // just short of the threshold
        {12'd410,  12'd3685, 8'd1,  1'b0, 4'b0000},
        // one count either side of centre
        {12'd2047, 12'd2049, 8'd1,  1'b0, 4'b0000},
        // hold left/up long enough to see the auto-repeat come round
        {12'd4095, 12'd4095, 8'd13, 1'b0, 4'b0000},
        // alternating bit patterns
        {12'h555,  12'hAAA,  8'd1,  1'b0, 4'b0000},
        {12'hAAA,  12'h555,  8'd1,  1'b0, 4'b0000},
        {12'hFFF,  12'h000,  8'd1,  1'b0, 4'b0000},
        {12'h000,  12'hFFF,  8'd1,  1'b0, 4'b0000}
    };

    function automatic logic [ADC_BITS-1:0] clamp_adc(int v);
        if (v < 0)
            return '0;
        if (v > ADC_MAX)
            return ADC_MAX[ADC_BITS-1:0];
        return v[ADC_BITS-1:0];
    endfunction

    // Compare one sample with centre, widen the extent on its side and
    // apply the 5*dev > 4*span test.
    task automatic judge_axis(input logic [ADC_BITS-1:0] s, c,
                              inout logic [ADC_BITS-1:0] mn, mx,
                              output logic below, above);
        below = 1'b0;
        above = 1'b0;
        if (s < c) begin
            if (s < mn)
                mn = s;
            below = 5 * (int'(c) - int'(s)) > 4 * (int'(c) - int'(mn));
        end else begin
            if (s > mx)
                mx = s;
            above = 5 * (int'(s) - int'(c)) > 4 * (int'(mx) - int'(c));
        end
    endtask

    task automatic step_hold(inout logic [GAP_BITS-1:0] cnt, input logic active,
                             output logic fire);
        fire = 1'b0;
        if (!active) begin
            cnt = '0;
        end else if (cnt == '0) begin
            cnt  = rep_gap;
            fire = 1'b1;
        end else begin
            cnt = cnt - 1'b1;
        end
    endtask

    task automatic predict_moves(input jdr_in_t smp, output jdr_out_t res);
        logic xb, xa, yb, ya;
        logic fu, fd, fl, fr;
        judge_axis(smp.sample_x, cen_x, ext_min_x, ext_max_x, xb, xa);
        judge_axis(smp.sample_y, cen_y, ext_min_y, ext_max_y, yb, ya);
        // X below centre is right, Y at or above centre is up
        step_hold(hold_up,    ya, fu);
        step_hold(hold_down,  yb, fd);
        step_hold(hold_left,  xa, fl);
        step_hold(hold_right, xb, fr);
        res.move_up    = fu;
        res.move_down  = fd;
        res.move_left  = fl;
        res.move_right = fr;
    endtask

    // Mirror a register write; calibration writes reload the running extents.
    function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_CENTER_X:   cen_x     = data[ADC_BITS-1:0];
            REG_LOW_X:      ext_min_x = data[ADC_BITS-1:0];
            REG_HIGH_X:     ext_max_x = data[ADC_BITS-1:0];
            REG_CENTER_Y:   cen_y     = data[ADC_BITS-1:0];
            REG_LOW_Y:      ext_min_y = data[ADC_BITS-1:0];
            REG_HIGH_Y:     ext_max_y = data[ADC_BITS-1:0];
            REG_REPEAT_GAP: rep_gap   = data[GAP_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Choose one axis sample inside a gesture zone, relative to the current
    // centre and extents, so that held gestures really qualify.
    function automatic logic [ADC_BITS-1:0] pick_axis(logic [ADC_BITS-1:0] c, mn, mx,
                                                       int zone);
        int ci, thr_lo, thr_hi, v;
        ci     = int'(c);
        thr_lo = ci - (4 * (ci - int'(mn))) / 5;
        thr_hi = ci + (4 * (int'(mx) - ci)) / 5;
        case (zone)
            ZONE_REST:    v = ci + int'($urandom_range(40)) - 20;
            ZONE_LOW:     v = int'($urandom_range(clamp_adc(thr_lo - 1)));
            ZONE_HIGH:    v = ADC_MAX - int'($urandom_range(ADC_MAX - clamp_adc(thr_hi + 1)));
            ZONE_LOW_TH:  v = thr_lo + int'($urandom_range(4)) - 2;
            ZONE_HIGH_TH: v = thr_hi + int'($urandom_range(4)) - 2;
            default:      v = int'($urandom_range(ADC_MAX));
        endcase
        return clamp_adc(v);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers. Inputs change on the falling edge; handshakes are
    // sampled on the rising edge.
    // ------------------------------------------------------------------

    // Predict, queue the expectation, then present the pair until the
    // transaction completes. Valid is left high for the next call to decide.
    task automatic push_sample(input jdr_in_t smp, input logic typed, input jdr_out_t want);
        jdr_out_t got;
        predict_moves(smp, got);
        pending_moves.push_back(typed ? want : got);
        @(negedge aclk);
        while (int'($urandom_range(99)) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= smp;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // Drop valid and hold off until every outstanding result is back.
    task automatic drain_pipeline;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ADC registers get random junk in the unused top bits; it must be masked.
    task automatic write_adc(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        write_reg(idx, {4'($urandom_range(15)), clamp_adc(val)});
    endtask

    task automatic configure_setting(input int p);
        int cx, cy;
        case (p)
            1: begin
                // widest calibration, no repeat gap
                write_adc(REG_CENTER_X, 2048);
                write_adc(REG_LOW_X, 0);
                write_adc(REG_HIGH_X, ADC_MAX);
                write_adc(REG_CENTER_Y, 2048);
                write_adc(REG_LOW_Y, 0);
                write_adc(REG_HIGH_Y, ADC_MAX);
                write_reg(REG_REPEAT_GAP, 16'd0);
            end
            2: begin
                // centres at the rails, longest repeat gap
                write_adc(REG_CENTER_X, 0);
                write_adc(REG_CENTER_Y, ADC_MAX);
                write_adc(REG_LOW_X, $urandom_range(ADC_MAX));
                write_adc(REG_HIGH_X, ADC_MAX);
                write_adc(REG_LOW_Y, 0);
                write_adc(REG_HIGH_Y, $urandom_range(ADC_MAX));
                write_reg(REG_REPEAT_GAP, 16'hFFFF);
            end
            4: begin
                // opposite rails, gap of one, and a write to the spare index
                write_adc(REG_CENTER_X, ADC_MAX);
                write_adc(REG_CENTER_Y, 0);
                write_adc(REG_LOW_X, $urandom_range(ADC_MAX));
                write_adc(REG_HIGH_Y, $urandom_range(ADC_MAX));
                write_reg(REG_REPEAT_GAP, 16'd1);
                write_reg(REG_SPARE, 16'($urandom));
            end
            default: begin
                // random centre; one time in five each extent is drawn from the whole
                // range and may land on the wrong side of centre
                cx = $urandom_range(ADC_MAX);
                cy = $urandom_range(ADC_MAX);
                write_adc(REG_CENTER_X, cx);
                write_adc(REG_CENTER_Y, cy);
                write_adc(REG_LOW_X,  ($urandom_range(4) == 0) ? $urandom_range(ADC_MAX)
                                                               : $urandom_range(cx));
                write_adc(REG_HIGH_X, ($urandom_range(4) == 0) ? $urandom_range(ADC_MAX)
                                                               : $urandom_range(ADC_MAX, cx));
                write_adc(REG_LOW_Y,  ($urandom_range(4) == 0) ? $urandom_range(ADC_MAX)
                                                               : $urandom_range(cy));
                write_adc(REG_HIGH_Y, ($urandom_range(4) == 0) ? $urandom_range(ADC_MAX)
                                                               : $urandom_range(ADC_MAX, cy));
                write_reg(REG_REPEAT_GAP, ($urandom_range(4) == 0) ? 16'($urandom)
                                                                   : 16'($urandom_range(15)));
                if ($urandom_range(1) == 0)
                    write_reg(REG_SPARE, 16'($urandom));
            end
        endcase
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, and a field-by-field check of
    // every transaction against the oldest expectation.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= (int'($urandom_range(99)) >= sink_stall_pct);
    end

    function automatic void check_field(string fname, logic want, logic got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected %b, actual %b", $time, fname, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        jdr_out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_moves.size() == 0) begin
                $display("%0t ns: unexpected result: expected none, actual %b",
                         $time, m_payload);
                fail_count++;
            end else begin
                want = pending_moves.pop_front();
                check_field("move_up",    want.move_up,    m_payload.move_up);
                check_field("move_down",  want.move_down,  m_payload.move_down);
                check_field("move_left",  want.move_left,  m_payload.move_left);
                check_field("move_right", want.move_right, m_payload.move_right);
                moves_checked++;
                events_fired += want.move_up + want.move_down + want.move_left
                              + want.move_right;
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", pending_moves.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        jdr_in_t smp;
        int      zx, zy, len, sent;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;

        // predictor starts from the reset calibration
        cen_x     = ADC_CENTER_RST;
        cen_y     = ADC_CENTER_RST;
        ext_min_x = ADC_LOW_RST;
        ext_min_y = ADC_LOW_RST;
        ext_max_x = ADC_HIGH_RST;
        ext_max_y = ADC_HIGH_RST;
        rep_gap   = GAP_RST;
        hold_up   = '0;
        hold_down = '0;
        hold_left = '0;
        hold_right = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, no idling on either side
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                smp.sample_x = dir_rows[r].x;
                smp.sample_y = dir_rows[r].y;
                push_sample(smp, dir_rows[r].typed, dir_rows[r].want);
            end
        end
        drain_pipeline();

        // Random phases: new calibration, then gesture-shaped sample runs
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0)
                configure_setting(p);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 15) begin
                    // short burst of noise
                    zx  = ZONE_ANY;
                    zy  = ZONE_ANY;
                    len = $urandom_range(4, 1);
                end else begin
                    // held gesture: deflect, rest or hover at the threshold
                    zx  = $urandom_range(ZONE_HIGH_TH);
                    zy  = $urandom_range(ZONE_HIGH_TH);
                    len = $urandom_range(40, 1);
                end
                for (int k = 0; k < len && sent < ITEMS_PER_PHASE; k++) begin
                    smp.sample_x = pick_axis(cen_x, ext_min_x, ext_max_x, zx);
                    smp.sample_y = pick_axis(cen_y, ext_min_y, ext_max_y, zy);
                    push_sample(smp, 1'b0, '0);
                    sent++;
                    // once mid-run, hold the sender until the block is empty
                    if (p == 1 && sent == ITEMS_PER_PHASE / 2)
                        drain_pipeline();
                end
            end
            drain_pipeline();
        end

        // let any stray result surface before the verdict
        repeat (8) @(posedge aclk);

        $display("Covered %0d sample pairs across %0d calibration settings and four idle patterns",
                 samples_sent, settings_used);
        $display("Checked %0d results carrying %0d direction events; %0d mismatches",
                 moves_checked, events_fired, fail_count);
        if (fail_count == 0 && pending_moves.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
